[src/force_table_velocity_integrator_top_assert.svh]
// Assertion macros for the force table velocity integrator.
// Expects clk and arst_n in the including module's scope.
`ifndef FORCE_TABLE_VELOCITY_INTEGRATOR_TOP_ASSERT_SVH
`define FORCE_TABLE_VELOCITY_INTEGRATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FTVI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FTVI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/ftvi_pkg.sv]
// Shared types and constants of the force table velocity integrator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package ftvi_pkg;
	localparam int MAX_FORCES = 8;
	localparam int USER_SLOTS = MAX_FORCES - 1;
	localparam int SLOT_W = $clog2(USER_SLOTS + 1);

	localparam int Q_W = 32;
	localparam int DIR_W = 18;
	localparam int MUL_W = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int SUM_W = 56;
	localparam int NV_W = 48;
	localparam int MAG_W = 47;
	localparam int SS_W = 64;
	localparam int ROOT_W = 32;
	localparam int QUO_W = 17;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = 17;
	localparam int STEP_W = 6;

	localparam logic signed [Q_W-1:0] ONE_Q16 = 32'sd65536;
	localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_TICK = 2'd1;
	localparam logic [1:0] KIND_SET_VEL = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_MAGNITUDE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TERMINAL_SPEED = 2'd2;
	localparam logic signed [Q_W-1:0] GRAVITY_MAG_RST = 32'sd642253;
	localparam logic [30:0] TERMINAL_SPEED_RST = 31'd6553600;

	typedef struct packed {
		logic [1:0] kind;
		logic signed [31:0] force_magnitude;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic [30:0] duration;
		logic is_constant;
		logic [30:0] delta_time;
	} in_item_t;

	typedef struct packed {
		logic accepted;
		logic signed [31:0] vel_out_x;
		logic signed [31:0] vel_out_y;
		logic signed [31:0] vel_out_z;
		logic basis_valid;
		logic signed [31:0] side_x;
		logic signed [31:0] side_y;
		logic signed [31:0] side_z;
		logic signed [31:0] heading_x;
		logic signed [31:0] heading_y;
		logic signed [31:0] heading_z;
	} result_t;

	typedef struct packed {
		logic go;
		logic is_sqrt;
	} rd_req_t;

	typedef struct packed {
		logic done;
		logic [ROOT_W-1:0] value;
	} rd_rsp_t;
endpackage

[src/force_table_velocity_integrator_top.sv]
// Force table velocity integrator: sequencer, force table and velocity state.
// Uses ftvi_pkg, ftvi_mul, ftvi_root_div and the assertion macro header.
//
//   channel  | ports                              | transfer
//   ---------+------------------------------------+----------------------------
//   item in  | start, busy, in_item               | start high while busy low
//   result   | done, result                       | every cycle with done high
//   config   | cfg_we, cfg_idx, cfg_data          | every cycle with cfg_we high
//
// One item at a time; busy is high from the transfer through the result cycle.
// Set velocity, clear and a rejected add go straight to the result.
// Add force: squares, the square root, three divisions and the result.
// A tick: each live slot, each idle one, the step, the scaling, the heading
// normalization, the speed check, the side one if the basis is valid, the clamp.
// Reset is asynchronous; the result is shown for one cycle and cannot be stalled.
`timescale 1ns / 1ps
`include "force_table_velocity_integrator_top_assert.svh"
module force_table_velocity_integrator_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input ftvi_pkg::in_item_t in_item,
	input logic cfg_we,
	input logic [ftvi_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [ftvi_pkg::Q_W-1:0] cfg_data,
	output logic done,
	output ftvi_pkg::result_t result
);
	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_SLOT   = 10'b00_0000_0010,
		S_NET    = 10'b00_0000_0100,
		S_SHIFT  = 10'b00_0000_1000,
		S_U_SQ   = 10'b00_0001_0000,
		S_U_ROOT = 10'b00_0010_0000,
		S_U_DIV  = 10'b00_0100_0000,
		S_TSQ    = 10'b00_1000_0000,
		S_CLAMP  = 10'b01_0000_0000,
		S_DONE   = 10'b10_0000_0000
	} state_t;

	localparam logic [1:0] RET_ADD = 2'd0;
	localparam logic [1:0] RET_HEAD = 2'd1;
	localparam logic [1:0] RET_SIDE = 2'd2;
	localparam logic [ftvi_pkg::MAG_W-1:0] FIT_LIMIT = ftvi_pkg::MAG_W'(64'h8000_0000);
	localparam logic signed [ftvi_pkg::SUM_W-1:0] NET_MAX = ftvi_pkg::SUM_W'(ftvi_pkg::Q_MAX);
	localparam logic signed [ftvi_pkg::SUM_W-1:0] NET_MIN = ftvi_pkg::SUM_W'(ftvi_pkg::Q_MIN);

	state_t state_q;
	logic [1:0] k_q;
	logic ph_q;
	logic [ftvi_pkg::SLOT_W-1:0] idx_q;
	logic [ftvi_pkg::SLOT_W-1:0] free_q;
	logic [1:0] ret_q;

	logic genable_q;
	logic signed [ftvi_pkg::Q_W-1:0] gmag_q;
	logic [30:0] term_q;

	logic signed [ftvi_pkg::Q_W-1:0] body_q [3];
	logic [ftvi_pkg::USER_SLOTS-1:0] used_q;

	logic signed [ftvi_pkg::Q_W-1:0] fmag_q;
	logic [30:0] dur_q;
	logic konst_q;
	logic [30:0] delta_q;

	logic signed [ftvi_pkg::SUM_W-1:0] sum_q [3];
	logic signed [ftvi_pkg::NV_W-1:0] nv_q [3];
	logic [ftvi_pkg::MAG_W-1:0] m_q [3];
	logic shifted_q;
	logic clamp_q;
	logic signed [ftvi_pkg::MUL_W-1:0] c_q [3];
	logic signed [ftvi_pkg::DIR_W-1:0] u_q [3];
	logic [ftvi_pkg::SS_W-1:0] ss_q;
	logic [ftvi_pkg::ROOT_W-1:0] len_q;
	logic signed [ftvi_pkg::DIR_W-1:0] head_q [3];
	logic signed [ftvi_pkg::DIR_W-1:0] side_q [3];
	logic accepted_q;
	logic valid_q;

	// force table entries: written on add, and a tick ages the time of live non-constant slots
	logic slot_const_q [ftvi_pkg::USER_SLOTS];
	logic signed [ftvi_pkg::Q_W-1:0] time_q [ftvi_pkg::USER_SLOTS];
	logic signed [ftvi_pkg::Q_W-1:0] smag_q [ftvi_pkg::USER_SLOTS];
	logic signed [ftvi_pkg::DIR_W-1:0] dir_q [ftvi_pkg::USER_SLOTS][3];

	logic signed [ftvi_pkg::MUL_W-1:0] mul_a;
	logic signed [ftvi_pkg::MUL_W-1:0] mul_b;
	logic signed [ftvi_pkg::PROD_W-1:0] prod_q;
	ftvi_pkg::rd_req_t rd_req;
	ftvi_pkg::rd_rsp_t rd_rsp;

	logic free_ok;
	logic [ftvi_pkg::SLOT_W-1:0] free_idx;
	logic signed [ftvi_pkg::MUL_W-1:0] c_abs;
	logic signed [ftvi_pkg::DIR_W-1:0] h_abs;
	logic signed [ftvi_pkg::SUM_W-1:0] net_sh;
	logic signed [ftvi_pkg::Q_W-1:0] net;
	logic [ftvi_pkg::SS_W-1:0] ss_nx;
	logic signed [ftvi_pkg::NV_W-1:0] nv_nx;
	logic signed [ftvi_pkg::NV_W-1:0] nv_abs;
	logic signed [ftvi_pkg::DIR_W-1:0] qv;
	logic signed [ftvi_pkg::DIR_W-1:0] u_new;
	logic signed [ftvi_pkg::DIR_W-1:0] u_fin [3];
	logic unit_end;
	logic too_big;
	logic signed [ftvi_pkg::Q_W:0] time_sub;
	logic signed [ftvi_pkg::Q_W-1:0] time_dec;
	logic slot_drop;
	logic slot_wr;
	logic time_wr;
	logic signed [ftvi_pkg::Q_W-1:0] clamp_q16;

	always_comb begin
		free_ok = 1'b0;
		free_idx = '0;
		for (int i = ftvi_pkg::USER_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_ok = 1'b1;
				free_idx = ftvi_pkg::SLOT_W'(i);
			end
		end
	end

	always_comb begin
		c_abs = c_q[k_q][ftvi_pkg::MUL_W-1] ? -c_q[k_q] : c_q[k_q];
		h_abs = head_q[k_q][ftvi_pkg::DIR_W-1] ? -head_q[k_q] : head_q[k_q];
		net_sh = sum_q[k_q] >>> 16;
		if (net_sh > NET_MAX) begin
			net = ftvi_pkg::Q_MAX;
		end else if (net_sh < NET_MIN) begin
			net = ftvi_pkg::Q_MIN;
		end else begin
			net = ftvi_pkg::Q_W'(net_sh);
		end
		ss_nx = ss_q + ftvi_pkg::SS_W'(prod_q);
		nv_nx = ftvi_pkg::NV_W'(body_q[k_q]) + ftvi_pkg::NV_W'(prod_q >>> 16);
		nv_abs = nv_nx[ftvi_pkg::NV_W-1] ? -nv_nx : nv_nx;
		too_big = (m_q[0] > FIT_LIMIT) || (m_q[1] > FIT_LIMIT) || (m_q[2] > FIT_LIMIT);
		clamp_q16 = ftvi_pkg::Q_W'(prod_q >>> 16);
		time_sub = ftvi_pkg::MUL_W'(time_q[idx_q]) - $signed({2'b00, delta_q});
		// saturate at the most negative 32-bit value
		time_dec = (time_sub[ftvi_pkg::Q_W] && !time_sub[ftvi_pkg::Q_W-1])
			? ftvi_pkg::Q_MIN : ftvi_pkg::Q_W'(time_sub);
		slot_drop = !used_q[idx_q] || (time_q[idx_q] <= 32'sd0);
	end

	always_comb begin
		qv = $signed({1'b0, rd_rsp.value[ftvi_pkg::QUO_W-1:0]});
		u_new = c_q[k_q][ftvi_pkg::MUL_W-1] ? -qv : qv;
		u_fin = u_q;
		unit_end = 1'b0;
		if (state_q == S_U_SQ && ph_q && k_q == 2'd2 && ss_nx == '0) begin
			unit_end = 1'b1;
			u_fin = '{default: '0};
		end
		if (state_q == S_U_DIV && ph_q && rd_rsp.done) begin
			u_fin[k_q] = u_new;
			unit_end = (k_q == 2'd2);
		end
		slot_wr = unit_end && ret_q == RET_ADD;
		time_wr = state_q == S_SLOT && !ph_q && k_q == 2'd0 && !slot_drop
			&& !slot_const_q[idx_q];
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SLOT: begin
				mul_a = ftvi_pkg::MUL_W'(dir_q[idx_q][k_q]);
				mul_b = ftvi_pkg::MUL_W'(smag_q[idx_q]);
			end
			S_U_SQ: begin
				mul_a = c_abs;
				mul_b = c_abs;
			end
			S_NET: begin
				mul_a = ftvi_pkg::MUL_W'(net);
				mul_b = $signed({2'b00, delta_q});
			end
			S_TSQ: begin
				mul_a = $signed({2'b00, term_q});
				mul_b = $signed({2'b00, term_q});
			end
			S_CLAMP: begin
				mul_a = ftvi_pkg::MUL_W'(h_abs);
				mul_b = $signed({2'b00, term_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		rd_req.go = (state_q == S_U_ROOT || state_q == S_U_DIV) && !ph_q;
		rd_req.is_sqrt = state_q == S_U_ROOT;
	end

	ftvi_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	ftvi_root_div u_root_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (rd_req),
		.radicand (ss_q),
		.dividend (c_abs[ftvi_pkg::ROOT_W-1:0]),
		.divisor  (len_q),
		.rsp      (rd_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
			ph_q <= 1'b0;
			idx_q <= '0;
			free_q <= '0;
			ret_q <= RET_ADD;
			genable_q <= 1'b0;
			gmag_q <= ftvi_pkg::GRAVITY_MAG_RST;
			term_q <= ftvi_pkg::TERMINAL_SPEED_RST;
			body_q <= '{default: '0};
			used_q <= '0;
			accepted_q <= 1'b0;
			valid_q <= 1'b0;
			shifted_q <= 1'b0;
			clamp_q <= 1'b0;
			head_q <= '{default: '0};
			side_q <= '{default: '0};
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					ftvi_pkg::CFG_GRAVITY_ENABLE: genable_q <= cfg_data[0];
					ftvi_pkg::CFG_GRAVITY_MAGNITUDE: gmag_q <= $signed(cfg_data);
					ftvi_pkg::CFG_TERMINAL_SPEED: term_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						accepted_q <= 1'b1;
						valid_q <= 1'b0;
						head_q <= '{default: '0};
						side_q <= '{default: '0};
						k_q <= '0;
						ph_q <= 1'b0;
						idx_q <= '0;
						shifted_q <= 1'b0;
						clamp_q <= 1'b0;
						ret_q <= RET_ADD;
						case (in_item.kind)
							ftvi_pkg::KIND_ADD: begin
								if (free_ok) begin
									free_q <= free_idx;
									state_q <= S_U_SQ;
								end else begin
									accepted_q <= 1'b0;
									state_q <= S_DONE;
								end
							end
							ftvi_pkg::KIND_TICK: state_q <= S_SLOT;
							ftvi_pkg::KIND_SET_VEL: begin
								body_q[0] <= in_item.vec_x;
								body_q[1] <= in_item.vec_y;
								body_q[2] <= in_item.vec_z;
								state_q <= S_DONE;
							end
							ftvi_pkg::KIND_CLEAR: begin
								used_q <= '0;
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SLOT: begin
					if (!ph_q) begin
						if (k_q == 2'd0 && slot_drop) begin
							// drop an expired slot and move on
							used_q[idx_q] <= 1'b0;
							if (idx_q == ftvi_pkg::SLOT_W'(ftvi_pkg::USER_SLOTS - 1)) begin
								idx_q <= '0;
								state_q <= S_NET;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						ph_q <= 1'b0;
						if (k_q == 2'd2) begin
							k_q <= '0;
							if (idx_q == ftvi_pkg::SLOT_W'(ftvi_pkg::USER_SLOTS - 1)) begin
								idx_q <= '0;
								state_q <= S_NET;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_NET: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						if (k_q == 2'd2) begin
							k_q <= '0;
							state_q <= S_SHIFT;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_SHIFT: begin
					if (too_big) begin
						shifted_q <= 1'b1;
					end else begin
						valid_q <= (m_q[0] | m_q[1] | m_q[2]) != '0;
						ret_q <= RET_HEAD;
						state_q <= S_U_SQ;
					end
				end
				S_U_SQ: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						if (k_q == 2'd2) begin
							k_q <= '0;
							state_q <= S_U_ROOT;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_U_ROOT: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (rd_rsp.done) begin
						ph_q <= 1'b0;
						state_q <= S_U_DIV;
					end
				end
				S_U_DIV: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (rd_rsp.done) begin
						ph_q <= 1'b0;
						k_q <= k_q + 1'b1;
					end
				end
				S_TSQ: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						clamp_q <= shifted_q || (ss_q > ftvi_pkg::SS_W'(prod_q));
						if (valid_q) begin
							ret_q <= RET_SIDE;
							state_q <= S_U_SQ;
						end else begin
							state_q <= S_CLAMP;
						end
					end
				end
				S_CLAMP: begin
					if (!clamp_q) begin
						for (int i = 0; i < 3; i++) begin
							body_q[i] <= ftvi_pkg::Q_W'(nv_q[i]);
						end
						state_q <= S_DONE;
					end else if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						body_q[k_q] <= head_q[k_q][ftvi_pkg::DIR_W-1] ? -clamp_q16 : clamp_q16;
						if (k_q == 2'd2) begin
							k_q <= '0;
							state_q <= S_DONE;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (unit_end) begin
				k_q <= '0;
				ph_q <= 1'b0;
				case (ret_q)
					RET_ADD: begin
						used_q[free_q] <= 1'b1;
						state_q <= S_DONE;
					end
					RET_HEAD: begin
						head_q <= u_fin;
						state_q <= S_TSQ;
					end
					RET_SIDE: begin
						side_q <= u_fin;
						state_q <= S_CLAMP;
					end
					default: state_q <= S_DONE;
				endcase
			end
		end
	end

	// working registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				fmag_q <= in_item.force_magnitude;
				dur_q <= in_item.duration;
				konst_q <= in_item.is_constant;
				delta_q <= in_item.delta_time;
				c_q[0] <= ftvi_pkg::MUL_W'(in_item.vec_x);
				c_q[1] <= ftvi_pkg::MUL_W'(in_item.vec_y);
				c_q[2] <= ftvi_pkg::MUL_W'(in_item.vec_z);
				ss_q <= '0;
				sum_q[0] <= '0;
				sum_q[1] <= genable_q ? -(ftvi_pkg::SUM_W'(gmag_q) <<< 16) : '0;
				sum_q[2] <= '0;
			end
			S_SLOT: begin
				if (ph_q) begin
					sum_q[k_q] <= sum_q[k_q] + ftvi_pkg::SUM_W'(prod_q);
				end
			end
			S_NET: begin
				if (ph_q) begin
					nv_q[k_q] <= nv_nx;
					m_q[k_q] <= ftvi_pkg::MAG_W'(nv_abs);
				end
			end
			S_SHIFT: begin
				for (int i = 0; i < 3; i++) begin
					if (too_big) begin
						m_q[i] <= m_q[i] >> 1;
					end else begin
						c_q[i] <= nv_q[i][ftvi_pkg::NV_W-1]
							? -$signed({1'b0, m_q[i][ftvi_pkg::Q_W-1:0]})
							: $signed({1'b0, m_q[i][ftvi_pkg::Q_W-1:0]});
					end
				end
				ss_q <= '0;
			end
			S_U_SQ: begin
				if (ph_q) begin
					ss_q <= ss_nx;
				end
				u_q <= u_fin;
			end
			S_U_ROOT: begin
				if (ph_q && rd_rsp.done) begin
					len_q <= rd_rsp.value;
				end
			end
			S_U_DIV: begin
				u_q <= u_fin;
			end
			S_TSQ: begin
				if (ph_q) begin
					c_q[0] <= ftvi_pkg::MUL_W'(head_q[2]);
					c_q[1] <= '0;
					c_q[2] <= -ftvi_pkg::MUL_W'(head_q[0]);
					ss_q <= '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_wr) begin
			slot_const_q[free_q] <= konst_q;
			time_q[free_q] <= konst_q ? ftvi_pkg::ONE_Q16 : $signed({1'b0, dur_q});
			smag_q[free_q] <= fmag_q;
			for (int i = 0; i < 3; i++) begin
				dir_q[free_q][i] <= u_fin[i];
			end
		end
		if (time_wr) begin
			time_q[idx_q] <= time_dec;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;

	always_comb begin
		result.accepted = accepted_q;
		result.vel_out_x = body_q[0];
		result.vel_out_y = body_q[1];
		result.vel_out_z = body_q[2];
		result.basis_valid = valid_q;
		result.side_x = ftvi_pkg::Q_W'(side_q[0]);
		result.side_y = ftvi_pkg::Q_W'(side_q[1]);
		result.side_z = ftvi_pkg::Q_W'(side_q[2]);
		result.heading_x = ftvi_pkg::Q_W'(head_q[0]);
		result.heading_y = ftvi_pkg::Q_W'(head_q[1]);
		result.heading_z = ftvi_pkg::Q_W'(head_q[2]);
	end

	`FTVI_ASSERT_NEXT(a_start_takes, start && !busy, busy, "accepted item did not raise busy")
	`FTVI_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
	`FTVI_ASSERT_NOW(a_side_flat, done, result.side_y == 32'sd0, "side vector has a y component")
	`FTVI_ASSERT_NOW(a_basis_clear, done && !result.basis_valid, result.heading_x == 32'sd0 && result.heading_y == 32'sd0 && result.heading_z == 32'sd0, "heading reported without a basis")
	`FTVI_ASSERT_NOW(a_unit_idle, state_q == S_IDLE, !rd_rsp.done, "root/divide unit finished while idle")
endmodule

[src/ftvi_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on ftvi_pkg for operand widths.
`timescale 1ns / 1ps
module ftvi_mul (
	input logic clk,
	input logic signed [ftvi_pkg::MUL_W-1:0] a,
	input logic signed [ftvi_pkg::MUL_W-1:0] b,
	output logic signed [ftvi_pkg::PROD_W-1:0] p_q
);
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule

[src/ftvi_root_div.sv]
// Iterative unit: integer square root (one result bit per cycle) or
// division of (dividend << 16) by a divisor with a 17-bit quotient. Uses ftvi_pkg.
`timescale 1ns / 1ps
module ftvi_root_div (
	input logic clk,
	input logic arst_n,
	input ftvi_pkg::rd_req_t req,
	input logic [ftvi_pkg::SS_W-1:0] radicand,
	input logic [ftvi_pkg::ROOT_W-1:0] dividend,
	input logic [ftvi_pkg::ROOT_W-1:0] divisor,
	output ftvi_pkg::rd_rsp_t rsp
);
	logic run_q;
	logic done_q;
	logic sqrt_q;
	logic [ftvi_pkg::STEP_W-1:0] cnt_q;
	logic [ftvi_pkg::SS_W-1:0] n_q;
	logic [ftvi_pkg::SS_W-1:0] res_q;
	logic [ftvi_pkg::SS_W-1:0] rbit_q;
	logic [ftvi_pkg::ROOT_W-1:0] rem_q;
	logic [ftvi_pkg::ROOT_W-1:0] dsr_q;
	logic [ftvi_pkg::QUO_W-1:0] dvd_q;
	logic [ftvi_pkg::QUO_W-1:0] quo_q;

	logic [ftvi_pkg::SS_W-1:0] root_try;
	logic [ftvi_pkg::ROOT_W:0] div_try;
	logic div_fit;

	always_comb begin
		root_try = res_q + rbit_q;
		div_try = {rem_q, dvd_q[ftvi_pkg::QUO_W-1]};
		div_fit = div_try >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			sqrt_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				sqrt_q <= req.is_sqrt;
				cnt_q <= req.is_sqrt ? ftvi_pkg::STEP_W'(ftvi_pkg::SQRT_STEPS - 1)
					: ftvi_pkg::STEP_W'(ftvi_pkg::DIV_STEPS - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			n_q <= radicand;
			res_q <= '0;
			rbit_q <= ftvi_pkg::SS_W'(1) << (ftvi_pkg::SS_W - 2);
			// quotient fits 17 bits, so the upper dividend bits start as remainder
			rem_q <= {1'b0, dividend[ftvi_pkg::ROOT_W-1:1]};
			dvd_q <= {dividend[0], {(ftvi_pkg::QUO_W - 1){1'b0}}};
			quo_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			if (sqrt_q) begin
				if (n_q >= root_try) begin
					n_q <= n_q - root_try;
					res_q <= (res_q >> 1) + rbit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				rbit_q <= rbit_q >> 2;
			end else begin
				rem_q <= div_fit ? ftvi_pkg::ROOT_W'(div_try - {1'b0, dsr_q})
					: ftvi_pkg::ROOT_W'(div_try);
				dvd_q <= dvd_q << 1;
				quo_q <= {quo_q[ftvi_pkg::QUO_W-2:0], div_fit};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.value = sqrt_q ? res_q[ftvi_pkg::ROOT_W-1:0] : ftvi_pkg::ROOT_W'(quo_q);
endmodule

[verif/tb_force_table_velocity_integrator_top.sv]
// Testbench for the force table velocity integrator: random and directed command stream,
// an in-bench predictor of velocity, force table and basis, and a per-field result check.
// Depends on ftvi_pkg and force_table_velocity_integrator_top.
`timescale 1ns / 1ps
module tb_force_table_velocity_integrator_top;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 400;
	localparam longint INT32_MIN_L = -64'sd2147483648;
	localparam longint INT32_MAX_L = 64'sd2147483647;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	ftvi_pkg::in_item_t in_item = '0;
	logic cfg_we = 1'b0;
	logic [ftvi_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [ftvi_pkg::Q_W-1:0] cfg_data = '0;
	logic done;
	ftvi_pkg::result_t result;

	force_table_velocity_integrator_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.done(done), .result(result)
	);

	always #4 clk = ~clk;

	// predictor state
	logic grav_on;
	longint grav_mag;
	longint term_speed;
	longint velocity [3];
	logic slot_live [ftvi_pkg::USER_SLOTS];
	logic slot_const [ftvi_pkg::USER_SLOTS];
	longint slot_time [ftvi_pkg::USER_SLOTS];
	longint slot_mag [ftvi_pkg::USER_SLOTS];
	longint slot_dir [ftvi_pkg::USER_SLOTS][3];

	ftvi_pkg::in_item_t pending_items [$];
	ftvi_pkg::result_t expected_results [$];
	int idle_pct = 0;
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_rejected = 0;
	int n_basis = 0;
	int n_clamped = 0;
	int quiet_cycles = 0;

	function automatic void queue_item(ftvi_pkg::in_item_t it);
		pending_items = {pending_items, it};
	endfunction

	function automatic longint unsigned magnitude(longint c);
		return c < 0 ? 64'd0 - longint'(c) : c;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= root + b) begin
				n -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	// components must stay within 2^31 in magnitude
	function automatic void unit_vector(input longint c [3], output longint u [3]);
		longint unsigned m [3];
		longint unsigned ss = 0;
		longint unsigned len;
		longint q;
		for (int i = 0; i < 3; i++) begin
			m[i] = magnitude(c[i]);
			ss += m[i] * m[i];
		end
		if (ss == 0) begin
			u = '{0, 0, 0};
			return;
		end
		len = int_sqrt(ss);
		for (int i = 0; i < 3; i++) begin
			q = longint'((m[i] << 16) / len);
			u[i] = c[i] < 0 ? -q : q;
		end
	endfunction

	function automatic longint sat32(longint v);
		if (v > INT32_MAX_L) return INT32_MAX_L;
		if (v < INT32_MIN_L) return INT32_MIN_L;
		return v;
	endfunction

	function automatic void predict_item(ftvi_pkg::in_item_t it);
		ftvi_pkg::result_t r;
		longint vec [3];
		longint dir [3];
		longint acc [3];
		longint nv [3];
		longint w [3];
		longint heading [3];
		longint side [3];
		longint cr [3];
		longint unsigned m [3];
		longint delta;
		longint t;
		longint q;
		int free_slot;
		int sh;
		logic clamp;
		r = '0;
		r.accepted = 1'b1;
		heading = '{0, 0, 0};
		side = '{0, 0, 0};
		vec[0] = longint'(it.vec_x);
		vec[1] = longint'(it.vec_y);
		vec[2] = longint'(it.vec_z);
		delta = longint'(it.delta_time);
		case (it.kind)
			ftvi_pkg::KIND_ADD: begin
				free_slot = -1;
				for (int i = ftvi_pkg::USER_SLOTS - 1; i >= 0; i--)
					if (!slot_live[i]) free_slot = i;
				if (free_slot < 0) begin
					r.accepted = 1'b0;
					n_rejected++;
				end else begin
					unit_vector(vec, dir);
					slot_live[free_slot] = 1'b1;
					slot_const[free_slot] = it.is_constant;
					slot_time[free_slot] = it.is_constant ? 64'sd65536 : longint'(it.duration);
					slot_mag[free_slot] = longint'(it.force_magnitude);
					for (int k = 0; k < 3; k++) slot_dir[free_slot][k] = dir[k];
				end
			end
			ftvi_pkg::KIND_SET_VEL: velocity = vec;
			ftvi_pkg::KIND_CLEAR: for (int i = 0; i < ftvi_pkg::USER_SLOTS; i++) slot_live[i] = 1'b0;
			default: begin
				acc = '{0, 0, 0};
				// drop expired forces, then age the rest
				for (int i = 0; i < ftvi_pkg::USER_SLOTS; i++)
					if (slot_live[i] && slot_time[i] <= 0) slot_live[i] = 1'b0;
				for (int i = 0; i < ftvi_pkg::USER_SLOTS; i++)
					if (slot_live[i] && !slot_const[i]) begin
						t = slot_time[i] - delta;
						slot_time[i] = t < INT32_MIN_L ? INT32_MIN_L : t;
					end
				if (grav_on) acc[1] += grav_mag * -64'sd65536;
				for (int i = 0; i < ftvi_pkg::USER_SLOTS; i++)
					if (slot_live[i])
						for (int k = 0; k < 3; k++) acc[k] += slot_dir[i][k] * slot_mag[i];
				for (int k = 0; k < 3; k++) begin
					nv[k] = velocity[k] + ((sat32(acc[k] >>> 16) * delta) >>> 16);
					m[k] = magnitude(nv[k]);
				end
				sh = 0;
				while ((m[0] >> sh) > 64'h8000_0000 || (m[1] >> sh) > 64'h8000_0000 ||
						(m[2] >> sh) > 64'h8000_0000)
					sh++;
				for (int k = 0; k < 3; k++) begin
					q = longint'(m[k] >> sh);
					w[k] = nv[k] < 0 ? -q : q;
				end
				unit_vector(w, heading);
				if ((m[0] | m[1] | m[2]) != 0) begin
					r.basis_valid = 1'b1;
					n_basis++;
					cr = '{heading[2], 0, -heading[0]};
					unit_vector(cr, side);
				end
				if (sh > 0) clamp = 1'b1;
				else clamp = m[0] * m[0] + m[1] * m[1] + m[2] * m[2] > term_speed * term_speed;
				if (clamp) n_clamped++;
				for (int k = 0; k < 3; k++) begin
					if (clamp) begin
						q = longint'((magnitude(heading[k]) * term_speed) >> 16);
						velocity[k] = heading[k] < 0 ? -q : q;
					end else begin
						velocity[k] = nv[k];
					end
				end
			end
		endcase
		r.vel_out_x = velocity[0][31:0];
		r.vel_out_y = velocity[1][31:0];
		r.vel_out_z = velocity[2][31:0];
		if (r.basis_valid) begin
			r.side_x = side[0][31:0];
			r.side_y = side[1][31:0];
			r.side_z = side[2][31:0];
			r.heading_x = heading[0][31:0];
			r.heading_y = heading[1][31:0];
			r.heading_z = heading[2][31:0];
		end
		expected_results = {expected_results, r};
	endfunction

	// driver: hold an item until it transfers, then maybe present the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				predict_item(in_item);
				n_sent++;
			end
			if (!start || !busy) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
					start <= 1'b1;
					in_item <= pending_items.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d (0x%08h), got %0d (0x%08h)", name,
				$signed(exp_v), exp_v, $signed(act_v), act_v);
			errors++;
		end
	endtask

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with no transfer outstanding");
				errors++;
			end else begin
				ftvi_pkg::result_t e;
				e = expected_results.pop_front();
				check_field("accepted", e.accepted, result.accepted);
				check_field("vel_out_x", e.vel_out_x, result.vel_out_x);
				check_field("vel_out_y", e.vel_out_y, result.vel_out_y);
				check_field("vel_out_z", e.vel_out_z, result.vel_out_z);
				check_field("basis_valid", e.basis_valid, result.basis_valid);
				check_field("side_x", e.side_x, result.side_x);
				check_field("side_y", e.side_y, result.side_y);
				check_field("side_z", e.side_z, result.side_z);
				check_field("heading_x", e.heading_x, result.heading_x);
				check_field("heading_y", e.heading_y, result.heading_y);
				check_field("heading_z", e.heading_z, result.heading_z);
				n_checked++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || cfg_we) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [ftvi_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			ftvi_pkg::CFG_GRAVITY_ENABLE: grav_on = val[0];
			ftvi_pkg::CFG_GRAVITY_MAGNITUDE: grav_mag = longint'($signed(val));
			default: term_speed = longint'(val[30:0]);
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] rand_word(int small_bits);
		logic [31:0] v;
		case ($urandom_range(9))
			0: v = 32'h8000_0000;
			1: v = 32'h7FFF_FFFF;
			2: v = $urandom();
			default: begin
				v = $urandom_range((1 << small_bits) - 1);
				if ($urandom_range(1)) v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic ftvi_pkg::in_item_t make_item(logic [1:0] k);
		ftvi_pkg::in_item_t it;
		it.kind = k;
		it.force_magnitude = rand_word(19);
		it.vec_x = rand_word(20);
		it.vec_y = rand_word(20);
		it.vec_z = rand_word(20);
		it.is_constant = ($urandom_range(3) == 0);
		it.duration = $urandom_range(7) == 0 ? 31'($urandom()) : 31'($urandom_range(4 * 65536));
		it.delta_time = $urandom_range(9) == 0 ? 31'($urandom()) : 31'($urandom_range(16384));
		if ($urandom_range(15) == 0) it.vec_x = '0;
		return it;
	endfunction

	function automatic logic [1:0] pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 35) return ftvi_pkg::KIND_ADD;
		if (r < 77) return ftvi_pkg::KIND_TICK;
		if (r < 91) return ftvi_pkg::KIND_SET_VEL;
		return ftvi_pkg::KIND_CLEAR;
	endfunction

	task automatic push_directed();
		ftvi_pkg::in_item_t it;
		it = make_item(ftvi_pkg::KIND_ADD);
		it.vec_x = '0; it.vec_y = '0; it.vec_z = '0;
		queue_item(it);
		it = make_item(ftvi_pkg::KIND_ADD);
		it.vec_x = 32'h8000_0000; it.vec_y = 32'h7FFF_FFFF; it.vec_z = 32'h8000_0000;
		it.force_magnitude = 32'h7FFF_FFFF; it.is_constant = 1'b1;
		queue_item(it);
		it = make_item(ftvi_pkg::KIND_ADD);
		it.force_magnitude = 32'h8000_0000; it.duration = '0; it.is_constant = 1'b0;
		queue_item(it);
		it = make_item(ftvi_pkg::KIND_ADD);
		it.duration = 31'h7FFF_FFFF; it.is_constant = 1'b0;
		queue_item(it);
		// fill the table and overflow it
		repeat (5) queue_item(make_item(ftvi_pkg::KIND_ADD));
		it = make_item(ftvi_pkg::KIND_TICK); it.delta_time = '0;
		queue_item(it);
		it = make_item(ftvi_pkg::KIND_TICK); it.delta_time = 31'h7FFF_FFFF;
		queue_item(it);
		it = make_item(ftvi_pkg::KIND_TICK); it.delta_time = 31'h7FFF_FFFF;
		queue_item(it);
		it = make_item(ftvi_pkg::KIND_CLEAR);
		queue_item(it);
		// straight-up heading gives a zero side vector
		it = make_item(ftvi_pkg::KIND_SET_VEL);
		it.vec_x = '0; it.vec_y = 32'h0001_0000; it.vec_z = '0;
		queue_item(it);
		it = make_item(ftvi_pkg::KIND_TICK); it.delta_time = '0;
		queue_item(it);
		it = make_item(ftvi_pkg::KIND_SET_VEL);
		it.vec_x = 32'h8000_0000; it.vec_y = 32'h8000_0000; it.vec_z = 32'h7FFF_FFFF;
		queue_item(it);
		it = make_item(ftvi_pkg::KIND_TICK); it.delta_time = 31'd1;
		queue_item(it);
		it = make_item(ftvi_pkg::KIND_SET_VEL);
		it.vec_x = '0; it.vec_y = '0; it.vec_z = '0;
		queue_item(it);
		it = make_item(ftvi_pkg::KIND_TICK); it.delta_time = '0;
		queue_item(it);
		queue_item(make_item(ftvi_pkg::KIND_CLEAR));
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_items.size() != 0 || start || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		grav_on = 1'b0;
		grav_mag = ftvi_pkg::GRAVITY_MAG_RST;
		term_speed = ftvi_pkg::TERMINAL_SPEED_RST;
		velocity = '{0, 0, 0};
		for (int i = 0; i < ftvi_pkg::USER_SLOTS; i++) slot_live[i] = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(ftvi_pkg::CFG_GRAVITY_ENABLE, 32'd1);
					write_reg(ftvi_pkg::CFG_GRAVITY_MAGNITUDE, 32'd642253);
					write_reg(ftvi_pkg::CFG_TERMINAL_SPEED, 32'd6553600);
				end
				1: begin
					write_reg(ftvi_pkg::CFG_GRAVITY_MAGNITUDE, 32'h8000_0000);
					write_reg(ftvi_pkg::CFG_TERMINAL_SPEED, 32'h7FFF_FFFF);
				end
				2: begin
					write_reg(ftvi_pkg::CFG_GRAVITY_MAGNITUDE, 32'h7FFF_FFFF);
					write_reg(ftvi_pkg::CFG_TERMINAL_SPEED, 32'd0);
				end
				3: begin
					write_reg(ftvi_pkg::CFG_GRAVITY_ENABLE, 32'd0);
					write_reg(ftvi_pkg::CFG_TERMINAL_SPEED, 32'd65536);
				end
				4: begin
					write_reg(ftvi_pkg::CFG_GRAVITY_ENABLE, 32'd1);
					write_reg(ftvi_pkg::CFG_GRAVITY_MAGNITUDE, $urandom());
					write_reg(ftvi_pkg::CFG_TERMINAL_SPEED, $urandom());
				end
				default: begin
					write_reg(ftvi_pkg::CFG_GRAVITY_MAGNITUDE, 32'd0);
					write_reg(ftvi_pkg::CFG_TERMINAL_SPEED, 32'd1000000);
				end
			endcase
			idle_pct = ph < 2 ? 31 : (ph < 4 ? 88 : 0);
			if (ph == 0) push_directed();
			repeat (215) queue_item(make_item(pick_kind()));
			wait_idle();
		end
		$display("covered %0d commands, %0d results checked: %0d rejected adds,",
			n_sent, n_checked, n_rejected);
		$display("%0d ticks with a heading, %0d speed clamps, six register settings",
			n_basis, n_clamped);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
